FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define LPR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define LPR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lpr_pkg.sv
// Shared types and constants of the linear phase rotator.
// No dependencies; used by every module of the block.
package lpr_pkg;

  localparam int GUARD_BITS    = 16;
  localparam int CORDIC_STEPS  = 20;
  localparam int ROUND_SHIFT   = GUARD_BITS - 1;
  localparam int TURN_BITS     = 32;
  localparam int LEN_BITS      = 17;
  localparam int CFG_BITS      = 32;
  localparam int GAIN_BITS     = 31;
  localparam logic [GAIN_BITS-1:0] INV_GAIN = 31'd1304065748;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 17'd1024;

  // atan(2^-k) in 2^-32 turn units
  localparam logic [TURN_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef enum logic [0:0] {
    REG_PHASE_STEP  = 1'b0,
    REG_BEAM_LENGTH = 1'b1
  } lpr_reg_t;

  // control carried alongside each word down the chain
  typedef struct packed {
    logic valid;
    logic last;
  } lpr_tag_t;

endpackage

FILE: hw/rtl/lpr_front.sv
// Front cell: config registers, beam counter, phase accumulator and quadrant pre-rotation.
// Depends on lpr_pkg.
module lpr_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 32,
  parameter int COUNT_BITS  = 16,
  parameter int W           = 35,
  parameter int ZW          = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lpr_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  output logic                          ready_o,
  output lpr_pkg::lpr_tag_t             tag_o,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [ZW-1:0]          z_o,
  input  logic                          ready_i
);

  localparam int LW = (COUNT_BITS + 1 > lpr_pkg::LEN_BITS) ? COUNT_BITS + 1
                                                           : lpr_pkg::LEN_BITS;
  localparam int TB = lpr_pkg::TURN_BITS;

  logic [PHASE_BITS-1:0]        step_r, step_nxt;
  logic [lpr_pkg::LEN_BITS-1:0] len_r, len_nxt;
  logic [COUNT_BITS-1:0]        count_r, count_nxt;
  logic [PHASE_BITS-1:0]        phase_r, phase_nxt;
  lpr_pkg::lpr_tag_t            tag_r, tag_nxt;
  logic signed [W-1:0]          x_r, y_r;
  logic signed [ZW-1:0]         z_r;

  logic                         take;
  logic                         last;
  logic [LW-1:0]                cnt_inc, len_w, cap, eff;
  logic [TB-1:0]                z32, zq, d;
  logic [1:0]                   quad;
  logic signed [SAMPLE_BITS:0]  xe, ye, xp, yp;

  assign ready_o = !tag_r.valid || ready_i;
  assign take    = in_valid && ready_o;

  // beam end: length 0 acts as 1, length above 2^COUNT_BITS is capped
  always_comb begin
    cnt_inc = LW'(count_r) + LW'(1);
    len_w   = LW'(len_r);
    cap     = LW'(1) << COUNT_BITS;
    if (len_w == '0) begin
      eff = LW'(1);
    end else if (len_w > cap) begin
      eff = cap;
    end else begin
      eff = len_w;
    end
    last = (cnt_inc >= eff);
  end

  always_comb begin
    step_nxt  = step_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    if (cfg_we) begin
      unique case (lpr_pkg::lpr_reg_t'(cfg_index))
        lpr_pkg::REG_PHASE_STEP:  step_nxt = cfg_data[PHASE_BITS-1:0];
        lpr_pkg::REG_BEAM_LENGTH: len_nxt  = cfg_data[lpr_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
    if (take) begin
      if (last) begin
        count_nxt = '0;
        phase_nxt = '0;
      end else begin
        count_nxt = count_r + COUNT_BITS'(1);
        phase_nxt = phase_r + step_r;
      end
    end
  end

  // nearest quarter turn applied exactly, remainder goes to the CORDIC
  always_comb begin
    z32  = TB'(phase_r) << (TB - PHASE_BITS);
    zq   = z32 + 32'h2000_0000;
    quad = zq[TB-1:TB-2];
    d    = z32 - {quad, {(TB-2){1'b0}}};
    xe   = (SAMPLE_BITS+1)'(in_i);
    ye   = (SAMPLE_BITS+1)'(in_q);
    unique case (quad)
      2'd1: begin
        xp = -ye;
        yp = xe;
      end
      2'd2: begin
        xp = -xe;
        yp = -ye;
      end
      2'd3: begin
        xp = ye;
        yp = -xe;
      end
      default: begin
        xp = xe;
        yp = ye;
      end
    endcase
  end

  always_comb begin
    tag_nxt = tag_r;
    if (ready_o) begin
      tag_nxt.valid = in_valid;
      tag_nxt.last  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      len_r   <= lpr_pkg::LEN_RESET;
      count_r <= '0;
      phase_r <= '0;
      tag_r   <= '0;
    end else begin
      step_r  <= step_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r <= W'(xp) <<< lpr_pkg::GUARD_BITS;
      y_r <= W'(yp) <<< lpr_pkg::GUARD_BITS;
      z_r <= ZW'(signed'(d));
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

FILE: hw/rtl/lpr_cordic_cell.sv
// One CORDIC micro-rotation cell of the chain, registered at its output.
// Depends on lpr_pkg for the arctangent table and the word tag.
module lpr_cordic_cell #(
  parameter int W    = 35,
  parameter int ZW   = 33,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpr_pkg::lpr_tag_t    tag_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 ready_o,
  output lpr_pkg::lpr_tag_t    tag_o,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o,
  input  logic                 ready_i
);

  lpr_pkg::lpr_tag_t    tag_r, tag_nxt;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt, sx, sy;
  logic signed [ZW-1:0] z_r, z_nxt, angle;

  assign ready_o = !tag_r.valid || ready_i;
  assign angle   = signed'(ZW'(lpr_pkg::ATAN_TURNS[STEP]));

  always_comb begin
    sx = x_i >>> STEP;
    sy = y_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - sy;
      y_nxt = y_i + sx;
      z_nxt = z_i - angle;
    end else begin
      x_nxt = x_i + sy;
      y_nxt = y_i - sx;
      z_nxt = z_i + angle;
    end
    tag_nxt = ready_o ? tag_i : tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && tag_i.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

FILE: hw/rtl/lpr_scale.sv
// Gain removal: magnitude, split multiply by the inverse CORDIC gain, round and saturate.
// Three registered steps, the last one is the output register. Depends on lpr_pkg.
module lpr_scale #(
  parameter int SAMPLE_BITS = 16,
  parameter int W           = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpr_pkg::lpr_tag_t             tag_i,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  output logic                          ready_o,
  output lpr_pkg::lpr_tag_t             tag_o,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  input  logic                          ready_i
);

  localparam int LO  = 32;
  localparam int GB  = lpr_pkg::GAIN_BITS;
  localparam int MW  = (W + 1 > LO + 1) ? W + 1 : LO + 1;
  localparam int PLW = LO + GB;
  localparam int PHW = MW - LO + GB;
  localparam int TW  = PHW + 1;
  localparam int RS  = lpr_pkg::ROUND_SHIFT;

  lpr_pkg::lpr_tag_t      t1_r, t2_r, t3_r, t1_nxt, t2_nxt, t3_nxt;
  logic                   r1, r2, r3;

  logic [MW-1:0]          mi_r, mq_r;
  logic                   ni1_r, nq1_r;
  logic [PLW-1:0]         pli_r, plq_r;
  logic [PHW-1:0]         phi_r, phq_r;
  logic                   ni2_r, nq2_r;
  logic signed [SAMPLE_BITS-1:0] oi_r, oq_r;

  logic signed [MW-1:0]   xe, ye;
  logic [MW-1:0]          mi, mq;
  logic signed [SAMPLE_BITS-1:0] oi_nxt, oq_nxt;

  // round(m * gain / 2^(31+guard)), ties away from zero, then clamp
  function automatic logic [SAMPLE_BITS-1:0] finish(input logic [PLW-1:0] pl,
                                                     input logic [PHW-1:0] ph,
                                                     input logic neg);
    logic [TW-1:0] t, r, hi;
    logic [SAMPLE_BITS-1:0] v;
    t  = TW'(pl[PLW-1:LO]) + TW'(ph);
    r  = (t + (TW'(1) << (RS - 1))) >> RS;
    hi = (TW'(1) << (SAMPLE_BITS - 1)) - TW'(1);
    if (!neg) begin
      v = (r > hi) ? SAMPLE_BITS'(hi) : SAMPLE_BITS'(r);
    end else if (r > hi + TW'(1)) begin
      v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      v = -SAMPLE_BITS'(r);
    end
    return v;
  endfunction

  assign r3      = !t3_r.valid || ready_i;
  assign r2      = !t2_r.valid || r3;
  assign r1      = !t1_r.valid || r2;
  assign ready_o = r1;

  always_comb begin
    xe     = MW'(x_i);
    ye     = MW'(y_i);
    mi     = xe[MW-1] ? unsigned'(-xe) : unsigned'(xe);
    mq     = ye[MW-1] ? unsigned'(-ye) : unsigned'(ye);
    oi_nxt = signed'(finish(pli_r, phi_r, ni2_r));
    oq_nxt = signed'(finish(plq_r, phq_r, nq2_r));
    t1_nxt = r1 ? tag_i : t1_r;
    t2_nxt = r2 ? t1_r : t2_r;
    t3_nxt = r3 ? t2_r : t3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      t3_r <= t3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && tag_i.valid) begin
      mi_r  <= mi;
      mq_r  <= mq;
      ni1_r <= x_i[W-1];
      nq1_r <= y_i[W-1];
    end
    if (r2 && t1_r.valid) begin
      pli_r <= PLW'(mi_r[LO-1:0] * lpr_pkg::INV_GAIN);
      plq_r <= PLW'(mq_r[LO-1:0] * lpr_pkg::INV_GAIN);
      phi_r <= PHW'(mi_r[MW-1:LO] * lpr_pkg::INV_GAIN);
      phq_r <= PHW'(mq_r[MW-1:LO] * lpr_pkg::INV_GAIN);
      ni2_r <= ni1_r;
      nq2_r <= nq1_r;
    end
    if (r3 && t2_r.valid) begin
      oi_r <= oi_nxt;
      oq_r <= oq_nxt;
    end
  end

  assign tag_o = t3_r;
  assign out_i = oi_r;
  assign out_q = oq_r;

endmodule

FILE: hw/rtl/linear_phase_rotator.sv
// An accepted input word passes the front cell, 20 CORDIC cells and 3 gain/round
// steps, each registered, to its result word; out_stall can hold it on the way.
// Throughput: one word per cycle unless out_stall holds the chain; each cell of the chain holds one word.
// Reset (rst_n low, synchronous): chain emptied, sample counter and phase cleared,
// phase_step 0, beam_length 1024.
module linear_phase_rotator #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lpr_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  output logic                          out_beam_end
);

  localparam int STEPS = lpr_pkg::CORDIC_STEPS;
  localparam int W     = SAMPLE_BITS + lpr_pkg::GUARD_BITS + 3;
  localparam int ZW    = lpr_pkg::TURN_BITS + 1;

  lpr_pkg::lpr_tag_t    tag_s [STEPS+1];
  logic signed [W-1:0]  x_s   [STEPS+1];
  logic signed [W-1:0]  y_s   [STEPS+1];
  logic signed [ZW-1:0] z_s   [STEPS+1];
  logic                 rdy_s [STEPS+1];
  logic                 front_ready;
  lpr_pkg::lpr_tag_t    out_tag;

  lpr_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .W          (W),
    .ZW         (ZW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_i     (in_i),
    .in_q     (in_q),
    .ready_o  (front_ready),
    .tag_o    (tag_s[0]),
    .x_o      (x_s[0]),
    .y_o      (y_s[0]),
    .z_o      (z_s[0]),
    .ready_i  (rdy_s[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    lpr_cordic_cell #(
      .W   (W),
      .ZW  (ZW),
      .STEP(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tag_i  (tag_s[k]),
      .x_i    (x_s[k]),
      .y_i    (y_s[k]),
      .z_i    (z_s[k]),
      .ready_o(rdy_s[k]),
      .tag_o  (tag_s[k+1]),
      .x_o    (x_s[k+1]),
      .y_o    (y_s[k+1]),
      .z_o    (z_s[k+1]),
      .ready_i(rdy_s[k+1])
    );
  end

  lpr_scale #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .W          (W)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_s[STEPS]),
    .x_i    (x_s[STEPS]),
    .y_i    (y_s[STEPS]),
    .ready_o(rdy_s[STEPS]),
    .tag_o  (out_tag),
    .out_i  (out_i),
    .out_q  (out_q),
    .ready_i(!out_stall)
  );

  assign in_stall     = !front_ready;
  assign out_valid    = out_tag.valid;
  assign out_beam_end = out_tag.last;

endmodule

FILE: hw/rtl/lpr_checker.sv
// Port-level checks of the linear phase rotator, bound to the top level.
// Depends on assert_macros.svh and lpr_pkg.
`include "assert_macros.svh"

module lpr_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int DEPTH       = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lpr_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_i,
  input  logic signed [SAMPLE_BITS-1:0] in_q,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_i,
  input  logic signed [SAMPLE_BITS-1:0] out_q,
  input  logic                          out_beam_end
);

  localparam int CW = $clog2(DEPTH + 2);

  logic          in_take, out_take;
  logic [CW-1:0] pend_r, pend_nxt;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // words taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_take && !out_take) begin
      pend_nxt = pend_r + CW'(1);
    end else if (!in_take && out_take) begin
      pend_nxt = pend_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `LPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_i) && $stable(out_q) && $stable(out_beam_end), "stalled output word changed")
  `LPR_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid right after reset")
  `LPR_ASSERT(a_no_phantom, out_valid, pend_r != '0, "output word with no input behind it")
  `LPR_ASSERT(a_depth, 1'b1, pend_r <= CW'(DEPTH), "more words in flight than the chain holds")

endmodule

bind linear_phase_rotator lpr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lpr_checker (.*);

FILE: tb/tb_linear_phase_rotator.sv
`timescale 1ns / 1ps
// Testbench for linear_phase_rotator: directed and random I/Q words checked
// against a bit-exact quadrant + CORDIC mixer predictor. Depends on lpr_pkg.
module tb_linear_phase_rotator;

  localparam logic [31:0] INV_GAIN_Q31 = 32'd1304065748;
  localparam logic [31:0] ARCTAN_Q32 [20] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };
  localparam int MAX_BEAM = 65536;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } rot_word_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_i;
  logic signed [15:0] in_q;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic               out_beam_end;

  // mixer state as the predictor sees it
  logic [31:0] cur_step;
  logic [16:0] cur_len;
  logic [15:0] beam_pos;
  logic [31:0] beam_phase;

  rot_word_t rot_due[$];
  int        err_count;
  int        gap_max;
  int        burst_left;
  int        stall_pct;
  int        stall_hold;
  logic      stall_now;

  linear_phase_rotator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_i        (in_i),
    .in_q        (in_q),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_i       (out_i),
    .out_q       (out_q),
    .out_beam_end(out_beam_end)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // remove CORDIC gain, round half away from zero, clamp to 16 bits
  function automatic logic signed [15:0] gain_saturate(input longint v);
    logic        neg;
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] r;
    longint      s;
    neg  = v < 0;
    mag  = neg ? -v : v;
    prod = mag * {64'd0, INV_GAIN_Q31};
    r    = (prod[95:32] + 64'd16384) >> 15;
    s    = neg ? -longint'(r) : longint'(r);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  function automatic rot_word_t rotate_sample(input logic signed [15:0] si,
                                              input logic signed [15:0] sq,
                                              input logic [31:0] ph);
    logic [31:0] biased;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      x, y, nx, ny, z;
    int          k;
    rot_word_t   w;
    biased = ph + 32'h2000_0000;
    quad   = biased[31:30];
    resid  = ph - {quad, 30'd0};
    z      = longint'($signed(resid));
    case (quad)
      2'd1: begin x = -longint'(sq); y = longint'(si); end
      2'd2: begin x = -longint'(si); y = -longint'(sq); end
      2'd3: begin x = longint'(sq); y = -longint'(si); end
      default: begin x = longint'(si); y = longint'(sq); end
    endcase
    x = x * 65536;
    y = y * 65536;
    for (k = 0; k < 20; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        ny = y + (x >>> k);
        z  = z - longint'(ARCTAN_Q32[k]);
      end else begin
        nx = x + (y >>> k);
        ny = y - (x >>> k);
        z  = z + longint'(ARCTAN_Q32[k]);
      end
      x = nx;
      y = ny;
    end
    w.re   = gain_saturate(x);
    w.im   = gain_saturate(y);
    w.last = 1'b0;
    return w;
  endfunction

  task automatic predict_rotation(input logic signed [15:0] si, input logic signed [15:0] sq);
    rot_word_t w;
    int        eff;
    w   = rotate_sample(si, sq, beam_phase);
    eff = (cur_len == 0) ? 1 : int'(cur_len);
    if (eff > MAX_BEAM) eff = MAX_BEAM;
    w.last = (int'(beam_pos) + 1) >= eff;
    if (w.last) begin
      beam_pos   = '0;
      beam_phase = '0;
    end else begin
      beam_pos   = beam_pos + 16'd1;
      beam_phase = beam_phase + cur_step;
    end
    rot_due = {rot_due, w};
  endtask

  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
    int n;
    if (gap_max != 0 && burst_left == 0) begin
      n = $urandom_range(gap_max, 1);
      repeat (n) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(16, 1);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_i     <= si;
    in_q     <= sq;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_rotation(si, sq);
  endtask

  // stop sending and wait until every predicted word has come out
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (rot_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lpr_pkg::lpr_reg_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      lpr_pkg::REG_PHASE_STEP:  cur_step = v;
      lpr_pkg::REG_BEAM_LENGTH: cur_len  = v[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults;
    gap_max   = 0;
    stall_pct = 0;
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'shFFFF);
    drain;
  endtask

  // quarter-turn steps, then eighth-turn steps that land on the rounding tie
  task automatic test_quadrants;
    int n;
    gap_max   = 3;
    stall_pct = 30;
    write_reg(lpr_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'd5);
    for (n = 0; n < 5; n++) send_sample(16'sh7FFF, 16'sh8000);
    drain;
    write_reg(lpr_pkg::REG_PHASE_STEP, 32'h2000_0000);
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'd4);
    for (n = 0; n < 4; n++) send_sample(16'sh7FFF, 16'sh7FFF);
    drain;
  endtask

  // low 17 bits zero, upper bits set: length 0 acts as 1
  task automatic test_zero_length;
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'hFFFE_0000);
    write_reg(lpr_pkg::REG_PHASE_STEP, 32'h1234_5678);
    send_sample(16'sh4000, 16'shC000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0001, 16'shFFFF);
    drain;
  endtask

  task automatic test_mid_beam;
    int n;
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'd8);
    write_reg(lpr_pkg::REG_PHASE_STEP, 32'h0800_0000);
    for (n = 0; n < 4; n++) send_sample(pick_sample(), pick_sample());
    drain;
    // counter already past the new length: next word ends the beam
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'd3);
    for (n = 0; n < 3; n++) send_sample(pick_sample(), pick_sample());
    drain;
    // new step only affects increments from here on
    write_reg(lpr_pkg::REG_PHASE_STEP, 32'hF000_0000);
    for (n = 0; n < 2; n++) send_sample(pick_sample(), pick_sample());
    drain;
  endtask

  task automatic test_random_phases;
    int          ph, n;
    logic [31:0] step;
    logic [16:0] len;
    for (ph = 0; ph < 11; ph++) begin
      case ($urandom_range(5))
        0: step = 32'h0000_0000;
        1: step = 32'hFFFF_FFFF;
        2: step = 32'h0000_0001;
        3: step = 32'h8000_0000;
        default: step = $urandom;
      endcase
      case ($urandom_range(7))
        0: len = 17'd0;
        1: len = 17'd1;
        2: len = 17'd65536;
        3, 4, 5: len = 17'($urandom_range(40, 2));
        6: len = 17'($urandom_range(400, 41));
        default: len = 17'($urandom);
      endcase
      case ((ph == 0) ? 2 : $urandom_range(2))
        0: write_reg(lpr_pkg::REG_PHASE_STEP, step);
        1: write_reg(lpr_pkg::REG_BEAM_LENGTH, {15'($urandom), len});
        default: begin
          write_reg(lpr_pkg::REG_PHASE_STEP, step);
          write_reg(lpr_pkg::REG_BEAM_LENGTH, {15'($urandom), len});
        end
      endcase
      gap_max   = (ph == 0) ? 0 : $urandom_range(8);
      stall_pct = (ph == 0) ? 0 : $urandom_range(60);
      for (n = 0; n < 140; n++) send_sample(pick_sample(), pick_sample());
      drain;
    end
  endtask

  // length above 2^16 is capped, never read as a short beam
  task automatic test_overlong_beam;
    int n;
    write_reg(lpr_pkg::REG_BEAM_LENGTH, 32'hFFFF_FFFF);
    write_reg(lpr_pkg::REG_PHASE_STEP, $urandom);
    gap_max   = 0;
    stall_pct = 20;
    for (n = 0; n < 80; n++) send_sample(16'($urandom), 16'($urandom));
    drain;
  endtask

  // receiver: stall runs of random length
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_now  = ($urandom_range(99) < stall_pct);
      stall_hold = $urandom_range(stall_now ? 6 : 10, 1);
    end
    stall_hold--;
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    rot_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (rot_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word i=%0d q=%0d end=%0b",
                                  out_i, out_q, out_beam_end));
      end else begin
        want = rot_due.pop_front();
        if (out_i !== want.re)
          report_mismatch($sformatf("out_i got %0d want %0d", out_i, want.re));
        if (out_q !== want.im)
          report_mismatch($sformatf("out_q got %0d want %0d", out_q, want.im));
        if (out_beam_end !== want.last)
          report_mismatch($sformatf("out_beam_end got %0b want %0b",
                                    out_beam_end, want.last));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_i       = '0;
    in_q       = '0;
    out_stall  = 1'b0;
    stall_pct  = 0;
    stall_hold = 0;
    stall_now  = 1'b0;
    gap_max    = 0;
    burst_left = 0;
    err_count  = 0;
    cur_step   = 32'd0;
    cur_len    = 17'd1024;
    beam_pos   = '0;
    beam_phase = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults;
    test_quadrants;
    test_zero_length;
    test_mid_beam;
    test_random_phases;
    test_overlong_beam;

    // pipeline is 24 deep; anything arriving now is a stray word
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_front.sv
hw/rtl/lpr_cordic_cell.sv
hw/rtl/lpr_scale.sv
hw/rtl/linear_phase_rotator.sv
hw/rtl/lpr_checker.sv
tb/tb_linear_phase_rotator.sv
